// File: hw/rtl/lpad_pkg.sv
// Types and constants shared by the argument deframer modules.
// No dependencies.
package lpad_pkg;

   typedef enum logic [1:0] {
      PH_COUNT  = 2'd0,
      PH_LEN_HI = 2'd1,
      PH_LEN_LO = 2'd2,
      PH_DATA   = 2'd3
   } phase_type;

   localparam logic [1:0] KIND_DATA        = 2'd0;
   localparam logic [1:0] KIND_EMPTY_ARG   = 2'd1;
   localparam logic [1:0] KIND_EMPTY_FRAME = 2'd2;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  args_remaining;
      logic [7:0]  current_arg;
      logic [7:0]  length_high;
      logic [15:0] current_length;
      logic [15:0] bytes_remaining;
   } ctx_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  arg_number;
      logic [7:0]  out_byte;
      logic [15:0] arg_length;
      logic        last_of_arg;
      logic        last_of_frame;
   } result_type;

endpackage

// File: hw/rtl/lpad_step.sv
// Per-byte parse step: next parser context and the optional result.
// Depends on lpad_pkg.
module lpad_step (
   input  lpad_pkg::ctx_type    ctx,
   input  logic [7:0]           in_byte,
   output lpad_pkg::ctx_type    ctx_next,
   output logic                 res_valid,
   output lpad_pkg::result_type res
);

   logic [15:0] full_length;
   logic [7:0]  args_dec;
   logic [15:0] bytes_dec;
   logic        arg_done;
   logic        last_arg;

   assign full_length = {ctx.length_high, in_byte};
   assign args_dec    = ctx.args_remaining - 8'd1;
   assign bytes_dec   = ctx.bytes_remaining - 16'd1;
   assign last_arg    = (ctx.args_remaining == 8'd1);

   always_comb begin
      arg_done = 1'b0;
      case (ctx.phase)
         lpad_pkg::PH_LEN_LO: arg_done = (full_length == 16'd0);
         lpad_pkg::PH_DATA:   arg_done = (ctx.bytes_remaining == 16'd1);
         default:             arg_done = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      ctx_next = ctx;
      case (ctx.phase)
         lpad_pkg::PH_COUNT: begin
            if (in_byte != 8'd0) begin
               ctx_next.args_remaining = in_byte;
               ctx_next.current_arg    = 8'd0;
               ctx_next.phase          = lpad_pkg::PH_LEN_HI;
            end
         end
         lpad_pkg::PH_LEN_HI: begin
            ctx_next.length_high = in_byte;
            ctx_next.phase       = lpad_pkg::PH_LEN_LO;
         end
         lpad_pkg::PH_LEN_LO: begin
            ctx_next.current_length = full_length;
            if (!arg_done) begin
               ctx_next.bytes_remaining = full_length;
               ctx_next.phase           = lpad_pkg::PH_DATA;
            end
         end
         lpad_pkg::PH_DATA: begin
            ctx_next.bytes_remaining = bytes_dec;
         end
         default: ctx_next = ctx;
      endcase
      if (arg_done) begin
         ctx_next.args_remaining = args_dec;
         if (args_dec == 8'd0) begin
            ctx_next.phase = lpad_pkg::PH_COUNT;
         end else begin
            ctx_next.current_arg = ctx.current_arg + 8'd1;
            ctx_next.phase       = lpad_pkg::PH_LEN_HI;
         end
      end
   end

   // outputs
   always_comb begin
      res_valid         = 1'b0;
      res.kind          = lpad_pkg::KIND_DATA;
      res.arg_number    = ctx.current_arg;
      res.out_byte      = 8'd0;
      res.arg_length    = 16'd0;
      res.last_of_arg   = 1'b0;
      res.last_of_frame = 1'b0;
      case (ctx.phase)
         lpad_pkg::PH_COUNT: begin
            res_valid         = (in_byte == 8'd0);
            res.kind          = lpad_pkg::KIND_EMPTY_FRAME;
            res.arg_number    = 8'd0;
            res.last_of_frame = 1'b1;
         end
         lpad_pkg::PH_LEN_LO: begin
            res_valid         = arg_done;
            res.kind          = lpad_pkg::KIND_EMPTY_ARG;
            res.last_of_arg   = 1'b1;
            res.last_of_frame = last_arg;
         end
         lpad_pkg::PH_DATA: begin
            res_valid         = 1'b1;
            res.out_byte      = in_byte;
            res.arg_length    = ctx.current_length;
            res.last_of_arg   = arg_done;
            res.last_of_frame = arg_done && last_arg;
         end
         default: res_valid = 1'b0;
      endcase
   end

endmodule

// File: hw/rtl/length_prefixed_argument_deframer_core.sv
// Length-prefixed argument deframer, top level. Depends on lpad_pkg, lpad_step.
// Pipeline: input register, then result register; a req transfer reaches rsp_valid through both.
// Throughput: one byte per cycle while a held rsp_ready does not stall the result register; the parse step
// is a single combinational pass between the input register and the result register.
// Reset: synchronous; parser returns to waiting for a count byte, both stages empty.
module length_prefixed_argument_deframer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_arg_number,
   output logic [7:0]  rsp_out_byte,
   output logic [15:0] rsp_arg_length,
   output logic        rsp_last_of_arg,
   output logic        rsp_last_of_frame
);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   lpad_pkg::result_type out_res_ff;
   lpad_pkg::ctx_type    ctx_ff;
   lpad_pkg::ctx_type    ctx_in;
   lpad_pkg::result_type step_res;
   logic                 step_valid;
   logic                 advance;

   lpad_step u_step (
      .ctx       (ctx_ff),
      .in_byte   (in_byte_ff),
      .ctx_next  (ctx_in),
      .res_valid (step_valid),
      .res       (step_res)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff && !rsp_ready;
      if (advance) begin
         out_valid_in = step_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
         ctx_ff.phase           <= lpad_pkg::PH_COUNT;
         ctx_ff.args_remaining  <= 8'd0;
         ctx_ff.current_arg     <= 8'd0;
         ctx_ff.length_high     <= 8'd0;
         ctx_ff.current_length  <= 16'd0;
         ctx_ff.bytes_remaining <= 16'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            ctx_ff <= ctx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance && step_valid) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_res_ff.kind;
   assign rsp_arg_number    = out_res_ff.arg_number;
   assign rsp_out_byte      = out_res_ff.out_byte;
   assign rsp_arg_length    = out_res_ff.arg_length;
   assign rsp_last_of_arg   = out_res_ff.last_of_arg;
   assign rsp_last_of_frame = out_res_ff.last_of_frame;

   a_args_live: assert property (@(posedge clock) disable iff (reset)
      ctx_ff.phase != lpad_pkg::PH_COUNT |-> ctx_ff.args_remaining != 8'd0)
      else $error("argument count exhausted outside count phase");

   a_data_left: assert property (@(posedge clock) disable iff (reset)
      ctx_ff.phase == lpad_pkg::PH_DATA |-> ctx_ff.bytes_remaining != 16'd0)
      else $error("data phase with no bytes remaining");

   a_empty_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == lpad_pkg::KIND_EMPTY_FRAME
         |-> rsp_last_of_frame && !rsp_last_of_arg)
      else $error("empty frame result with wrong flags");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("stalled input stage lost its byte");

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for length_prefixed_argument_deframer_core.
// Predicts every result from the byte stream and compares each rsp transfer against it.
// Depends on lpad_pkg and the core RTL only.
module tb_top;

   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          RANDOM_ITEMS = 1100;
   localparam int          DRAIN_CYCLES = 8;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_arg_number;
   logic [7:0]  rsp_out_byte;
   logic [15:0] rsp_arg_length;
   logic        rsp_last_of_arg;
   logic        rsp_last_of_frame;

   length_prefixed_argument_deframer_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_arg_number    (rsp_arg_number),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_arg_length    (rsp_arg_length),
      .rsp_last_of_arg   (rsp_last_of_arg),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   // parser state mirror
   lpad_pkg::phase_type prs_phase = lpad_pkg::PH_COUNT;
   logic [7:0]  prs_args_left = 8'd0;
   logic [7:0]  prs_arg_index = 8'd0;
   logic [7:0]  prs_len_high = 8'd0;
   logic [15:0] prs_arg_len = 16'd0;
   logic [15:0] prs_data_left = 16'd0;

   lpad_pkg::result_type expected_results[$];
   logic [7:0]  frame_bytes[$];
   lpad_pkg::result_type want_result;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned bytes_sent = 0;
   int          burst_left = 0;
   bit          tx_idle = 1'b0;
   bit          rx_fast = 1'b0;
   bit          hold_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic void close_argument();
      prs_args_left = prs_args_left - 8'd1;
      if (prs_args_left == 8'd0) begin
         prs_phase = lpad_pkg::PH_COUNT;
      end else begin
         prs_arg_index = prs_arg_index + 8'd1;
         prs_phase = lpad_pkg::PH_LEN_HI;
      end
   endfunction

   function automatic void deframe_byte(input logic [7:0] b);
      lpad_pkg::result_type r;
      r = '0;
      case (prs_phase)
         lpad_pkg::PH_COUNT: begin
            if (b == 8'd0) begin
               r.kind = lpad_pkg::KIND_EMPTY_FRAME;
               r.last_of_frame = 1'b1;
               expected_results.push_back(r);
            end else begin
               prs_args_left = b;
               prs_arg_index = 8'd0;
               prs_phase = lpad_pkg::PH_LEN_HI;
            end
         end
         lpad_pkg::PH_LEN_HI: begin
            prs_len_high = b;
            prs_phase = lpad_pkg::PH_LEN_LO;
         end
         lpad_pkg::PH_LEN_LO: begin
            prs_arg_len = {prs_len_high, b};
            if (prs_arg_len == 16'd0) begin
               r.kind = lpad_pkg::KIND_EMPTY_ARG;
               r.arg_number = prs_arg_index;
               r.last_of_arg = 1'b1;
               r.last_of_frame = (prs_args_left == 8'd1);
               expected_results.push_back(r);
               close_argument();
            end else begin
               prs_data_left = prs_arg_len;
               prs_phase = lpad_pkg::PH_DATA;
            end
         end
         default: begin
            r.kind = lpad_pkg::KIND_DATA;
            r.arg_number = prs_arg_index;
            r.out_byte = b;
            r.arg_length = prs_arg_len;
            r.last_of_arg = (prs_data_left == 16'd1);
            r.last_of_frame = r.last_of_arg && (prs_args_left == 8'd1);
            expected_results.push_back(r);
            prs_data_left = prs_data_left - 16'd1;
            if (prs_data_left == 16'd0) close_argument();
         end
      endcase
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, got kind %0d arg %0d byte %0d",
                     $time, rsp_kind, rsp_arg_number, rsp_out_byte);
            mismatch_count++;
         end else begin
            want_result = expected_results.pop_front();
            check_field("kind", 16'(want_result.kind), 16'(rsp_kind));
            check_field("arg_number", 16'(want_result.arg_number), 16'(rsp_arg_number));
            check_field("out_byte", 16'(want_result.out_byte), 16'(rsp_out_byte));
            check_field("arg_length", want_result.arg_length, rsp_arg_length);
            check_field("last_of_arg", 16'(want_result.last_of_arg), 16'(rsp_last_of_arg));
            check_field("last_of_frame", 16'(want_result.last_of_frame),
                        16'(rsp_last_of_frame));
         end
      end
   end

   // result sink: stall pattern of its own, plus long hold-off on request
   initial begin : receiver
      int hold_count;
      int mode;
      int mode_left;
      mode = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            if (rx_fast || mode == 0) begin
               rsp_ready <= 1'b1;
            end else if (mode == 1) begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end else if (mode == 2) begin
               rsp_ready <= ($urandom_range(0, 3) == 0);
            end else begin
               rsp_ready <= mode_left[2];
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] value);
      int gap;
      if (tx_idle && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         burst_left = $urandom_range(1, 16);
         req_valid <= 1'b0;
         req_in_byte <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_in_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      deframe_byte(value);
      bytes_sent++;
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_frame_prefix(input int n);
      for (int i = 0; i < n; i++) send_byte(frame_bytes[i]);
   endtask

   function automatic void build_frame(input int count, input int len_max,
                                       input int data_max);
      int len;
      int pick;
      frame_bytes.delete();
      frame_bytes.push_back(8'(count));
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 59);
         if (pick == 0) len = $urandom_range(256, 300);
         else if (pick < 12) len = 0;
         else len = $urandom_range(1, len_max);
         frame_bytes.push_back(8'(len >> 8));
         frame_bytes.push_back(8'(len));
         for (int j = 0; j < len; j++) frame_bytes.push_back(8'($urandom_range(0, data_max)));
      end
   endfunction

   function automatic int pick_count();
      int r;
      r = $urandom_range(0, 39);
      if (r == 0) return 0;
      if (r < 30) return $urandom_range(1, 4);
      if (r < 39) return $urandom_range(5, 16);
      return $urandom_range(17, 48);
   endfunction

   // bring the parser back to waiting for a count byte
   task automatic resync_parser();
      while (prs_phase != lpad_pkg::PH_COUNT) begin
         case (prs_phase)
            lpad_pkg::PH_LEN_HI: send_byte(8'd0);
            lpad_pkg::PH_LEN_LO: send_byte(8'($urandom_range(0, 2)));
            default:             send_byte(8'($urandom));
         endcase
      end
   endtask

   task automatic test_directed();
      logic [7:0] seq[$];
      seq = {8'h00,
             8'h01, 8'h00, 8'h00,
             8'h02, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00,
             8'h03, 8'h00, 8'h02, 8'h00, 8'hA5, 8'h00, 8'h00, 8'h00, 8'h01, 8'h5A};
      tx_idle = 1'b0;
      foreach (seq[i]) send_byte(seq[i]);
      wait_results_drained();
   endtask

   task automatic test_hold_off();
      tx_idle = 1'b0;
      hold_request = 1'b1;
      frame_bytes = {8'h02, 8'h00, 8'h14};
      for (int i = 0; i < 20; i++) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(8'h0F);
      for (int i = 0; i < 15; i++) frame_bytes.push_back(8'($urandom));
      send_frame_prefix(frame_bytes.size());
      wait_results_drained();
   endtask

   task automatic test_max_count();
      tx_idle = 1'b1;
      frame_bytes = {8'hFF};
      for (int i = 0; i < 255; i++) begin
         frame_bytes.push_back(8'h00);
         if (i % 64 == 63 || i == 254) begin
            frame_bytes.push_back(8'h02);
            frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(8'($urandom));
         end else begin
            frame_bytes.push_back(8'h00);
         end
      end
      send_frame_prefix(frame_bytes.size());
      wait_results_drained();
   endtask

   task automatic test_long_length();
      tx_idle = 1'b0;
      rx_fast = 1'b1;
      send_byte(8'h01);
      send_byte(8'h01);
      send_byte(8'h01);
      for (int i = 0; i < 257; i++) send_byte(8'($urandom));
      wait_results_drained();
      rx_fast = 1'b0;
   endtask

   task automatic test_random();
      int unsigned start;
      int choice;
      start = bytes_sent;
      tx_idle = 1'b1;
      while (bytes_sent - start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) tx_idle = !tx_idle;
         choice = $urandom_range(0, 99);
         if (choice < 6) begin
            // noise; keep high length bytes small so recovery stays short
            repeat ($urandom_range(1, 8)) begin
               if (prs_phase == lpad_pkg::PH_LEN_HI) send_byte(8'($urandom_range(0, 3) == 0));
               else if (prs_phase == lpad_pkg::PH_COUNT) send_byte(8'($urandom_range(0, 7)));
               else send_byte(8'($urandom));
            end
            resync_parser();
         end else if (choice < 12) begin
            // truncated frame, then a small frame that continues it
            build_frame($urandom_range(1, 4), 6, 255);
            send_frame_prefix($urandom_range(1, frame_bytes.size()));
            build_frame($urandom_range(0, 1), 1, 1);
            send_frame_prefix(frame_bytes.size());
            resync_parser();
         end else begin
            build_frame(pick_count(), ($urandom_range(0, 4) == 0) ? 24 : 4, 255);
            send_frame_prefix(frame_bytes.size());
         end
         if (choice == 95) hold_request = 1'b1;
         if (choice >= 97) wait_results_drained();
      end
      wait_results_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_hold_off();
      test_max_count();
      test_long_length();
      test_random();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/lpad_pkg.sv
hw/rtl/lpad_step.sv
hw/rtl/length_prefixed_argument_deframer_core.sv
verif/tb_top.sv
